@@ rtl/core/tss_pkg.sv @@
// ----------------------------------------------------------------------------
// tss_pkg: shared types and constants
// Widths, calibration constants, controller states, command and status
// structs, and the seven-segment code table.
// ----------------------------------------------------------------------------
package tss_pkg;

	localparam int SAMPLE_W  = 12;
	localparam int CAL_W     = 12;
	localparam int DIFF_W    = 13;  // signed sample - cal_low
	localparam int NUM_W     = 20;  // signed (sample - cal_low) * 80
	localparam int NUM_MAG_W = 19;  // |num| <= 327600
	localparam int DVS_W     = 12;  // |cal_high - cal_low| <= 4095
	localparam int TEMP_W    = 7;
	localparam int SEG_W     = 8;
	localparam int DIGIT_W   = 4;
	localparam int CNT_W     = 5;
	localparam int DIV_STEPS = NUM_MAG_W;
	localparam int IDX_W     = 1;

	localparam logic [IDX_W-1:0] REG_CAL_LOW  = 1'b0;
	localparam logic [IDX_W-1:0] REG_CAL_HIGH = 1'b1;

	localparam logic [CAL_W-1:0] CAL_LOW_RST  = 12'd1750;
	localparam logic [CAL_W-1:0] CAL_HIGH_RST = 12'd1330;

	localparam logic [TEMP_W-1:0] COLD_C = 7'd30;
	localparam logic [TEMP_W-1:0] TOP_C  = 7'd100;
	// largest quotient magnitudes that still land in 1..100
	localparam logic [NUM_MAG_W-1:0] MAX_POS_Q = 19'd70;
	localparam logic [NUM_MAG_W-1:0] MAX_NEG_Q = 19'd29;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EVAL
	} tss_state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic eval;
	} tss_cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_busy;
	} tss_status_t;

	// common-cathode codes, bit0 = segment a
	function automatic logic [SEG_W-1:0] seg_code(input logic [DIGIT_W-1:0] d);
		logic [SEG_W-1:0] c;
		case (d)
			4'd0:    c = 8'h3f;
			4'd1:    c = 8'h06;
			4'd2:    c = 8'h5b;
			4'd3:    c = 8'h4f;
			4'd4:    c = 8'h66;
			4'd5:    c = 8'h6d;
			4'd6:    c = 8'h7d;
			4'd7:    c = 8'h07;
			4'd8:    c = 8'h7f;
			4'd9:    c = 8'h6f;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

@@ rtl/core/temp_sensor_to_seven_segment.sv @@
// ----------------------------------------------------------------------------
// temp_sensor_to_seven_segment: calibrated ADC temperature to digit codes
// Top level: sequencer plus datapath.
// ----------------------------------------------------------------------------
// Converts one 12-bit ADC reading of the temperature sensor per transfer into
// whole degrees Celsius by two-point calibration: (sample - cal_low_point) * 80
// divided by (cal_high_point - cal_low_point), truncated toward zero, plus 30.
// A result in 1..100 replaces the held temperature and raises updated;
// anything else, including equal calibration points, keeps the old value with
// updated low. Each result carries the held value and common-cathode segment
// codes (bit0 = segment a) for its ones, tens, hundreds and thousands digits.
// Each item goes from the input transfer, whose edge latches the operands,
// through the bit-serial restoring divider (one quotient bit per cycle, one
// step for each bit of the 19-bit numerator magnitude) to the commit that
// sets output valid. The input reopens the cycle after the commit, so no
// sample is taken while one is converting; a stalled output delays the
// commit. A new sample is taken once the previous one has been committed,
// even while its result still waits in the output register. Calibration
// registers are written through cfg_we/cfg_index/cfg_data (index 0 low point,
// 1 high point) and should only change while no conversion is in flight.
module temp_sensor_to_seven_segment (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tss_pkg::IDX_W-1:0]      cfg_index,
	input  logic [tss_pkg::CAL_W-1:0]      cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [tss_pkg::SAMPLE_W-1:0]   sample,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [tss_pkg::TEMP_W-1:0]     shown_temp,
	output logic                          updated,
	output logic [tss_pkg::SEG_W-1:0]      seg_ones,
	output logic [tss_pkg::SEG_W-1:0]      seg_tens,
	output logic [tss_pkg::SEG_W-1:0]      seg_hundreds,
	output logic [tss_pkg::SEG_W-1:0]      seg_thousands
);
	import tss_pkg::*;

	tss_cmd_t    cmd;
	tss_status_t status;

	// sequencer: idle -> divide -> commit
	tss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// calibration, divider, held value and output register
	tss_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.sample        (sample),
		.cmd           (cmd),
		.status        (status),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.shown_temp    (shown_temp),
		.updated       (updated),
		.seg_ones      (seg_ones),
		.seg_tens      (seg_tens),
		.seg_hundreds  (seg_hundreds),
		.seg_thousands (seg_thousands)
	);

	// the held value never leaves 0..100
	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		shown_temp <= TOP_C)
		else $error("shown_temp out of range");

	// an update always carries a nonzero temperature
	a_update_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && updated |-> shown_temp != '0)
		else $error("updated with zero temperature");

	// once a sample is taken the input side is busy for the divide
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while converting");

	// thousands digit always shows the zero code
	a_thousands_zero: assert property (@(posedge clk) disable iff (!arst_n)
		seg_thousands == seg_code(4'd0))
		else $error("thousands digit not zero");

endmodule

@@ rtl/core/tss_ctrl.sv @@
// ----------------------------------------------------------------------------
// tss_ctrl: conversion sequencer
// Accepts a sample, runs the serial divide, then commits the result once the
// output register is free.
// ----------------------------------------------------------------------------
module tss_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  tss_pkg::tss_status_t status,
	output tss_pkg::tss_cmd_t   cmd
);
	import tss_pkg::*;

	tss_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				if (status.div_done) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				// wait while the previous result is still held up
				if (!status.out_busy) begin
					cmd.eval = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/core/tss_dp.sv @@
// ----------------------------------------------------------------------------
// tss_dp: conversion datapath
// Calibration registers, operand setup, restoring divider, range check,
// held temperature and output register with digit decode.
// ----------------------------------------------------------------------------
module tss_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [tss_pkg::IDX_W-1:0]              cfg_index,
	input  logic [tss_pkg::CAL_W-1:0]              cfg_data,
	input  logic [tss_pkg::SAMPLE_W-1:0]           sample,
	input  tss_pkg::tss_cmd_t                     cmd,
	output tss_pkg::tss_status_t                  status,
	input  logic                                  out_stall,
	output logic                                  out_valid,
	output logic [tss_pkg::TEMP_W-1:0]             shown_temp,
	output logic                                  updated,
	output logic [tss_pkg::SEG_W-1:0]              seg_ones,
	output logic [tss_pkg::SEG_W-1:0]              seg_tens,
	output logic [tss_pkg::SEG_W-1:0]              seg_hundreds,
	output logic [tss_pkg::SEG_W-1:0]              seg_thousands
);
	import tss_pkg::*;

	logic [CAL_W-1:0]     cal_low_q, cal_high_q;
	logic [DVS_W-1:0]     dvs_q;
	logic [DVS_W-1:0]     rem_q;
	logic [NUM_MAG_W-1:0] quo_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 qneg_q, dvs_zero_q;
	logic [TEMP_W-1:0]    held_q;
	logic                 updated_q, out_valid_q;

	// operand setup
	logic [DIFF_W-1:0]    diff, span;
	logic [NUM_W-1:0]     diff_ext, num, num_mag_full;
	logic [DIFF_W-1:0]    span_mag_full;

	assign diff     = {1'b0, sample} - {1'b0, cal_low_q};
	assign span     = {1'b0, cal_high_q} - {1'b0, cal_low_q};
	assign diff_ext = {{(NUM_W-DIFF_W){diff[DIFF_W-1]}}, diff};
	// x * 80 = x * 64 + x * 16
	assign num      = (diff_ext << 6) + (diff_ext << 4);
	assign num_mag_full  = num[NUM_W-1] ? (~num + 1'b1) : num;
	assign span_mag_full = span[DIFF_W-1] ? (~span + 1'b1) : span;

	// one restoring step
	logic [DVS_W:0] shifted, trial;
	logic           ge;

	assign shifted = {rem_q, quo_q[NUM_MAG_W-1]};
	assign trial   = shifted - {1'b0, dvs_q};
	assign ge      = !trial[DVS_W];

	// range check on the finished quotient
	logic              accept;
	logic [TEMP_W-1:0] temp_new;

	assign accept   = !dvs_zero_q && (qneg_q ? (quo_q <= MAX_NEG_Q) : (quo_q <= MAX_POS_Q));
	assign temp_new = qneg_q ? (COLD_C - quo_q[TEMP_W-1:0]) : (COLD_C + quo_q[TEMP_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_low_q  <= CAL_LOW_RST;
			cal_high_q <= CAL_HIGH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CAL_LOW:  cal_low_q  <= cfg_data;
				REG_CAL_HIGH: cal_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dvs_q      <= span_mag_full[DVS_W-1:0];
			dvs_zero_q <= (span == '0);
			qneg_q     <= num[NUM_W-1] ^ span[DIFF_W-1];
			quo_q      <= num_mag_full[NUM_MAG_W-1:0];
			rem_q      <= '0;
		end else if (cmd.step) begin
			rem_q <= ge ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
			quo_q <= {quo_q[NUM_MAG_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= '0;
		end else if (cmd.step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= '0;
			updated_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (cmd.eval) begin
			if (accept) begin
				held_q <= temp_new;
			end
			updated_q   <= accept;
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.div_done = (cnt_q == CNT_W'(DIV_STEPS - 1));
	assign status.out_busy = out_valid_q && out_stall;

	// digit split of the held value (0..100)
	logic                hund;
	logic [TEMP_W-1:0]   rem_tens;
	logic [14:0]         tens_prod;
	logic [DIGIT_W-1:0]  tens_d, ones_d;
	logic [TEMP_W-1:0]   ones_full;

	assign hund      = (held_q >= TOP_C);
	assign rem_tens  = hund ? (held_q - TOP_C) : held_q;
	// /10 by reciprocal: (x * 205) >> 11 is exact for x < 1029
	assign tens_prod = 15'(rem_tens) * 15'd205;
	assign tens_d    = tens_prod[14:11];
	assign ones_full = rem_tens - {tens_d, 3'b000} - {2'b00, tens_d, 1'b0};
	assign ones_d    = ones_full[DIGIT_W-1:0];

	assign out_valid     = out_valid_q;
	assign shown_temp    = held_q;
	assign updated       = updated_q;
	assign seg_ones      = seg_code(ones_d);
	assign seg_tens      = seg_code(tens_d);
	assign seg_hundreds  = seg_code({3'b000, hund});
	// a 7-bit value never reaches a thousands digit
	assign seg_thousands = seg_code(4'd0);

endmodule

@@ tb/temp_sensor_to_seven_segment_tb.sv @@
// ----------------------------------------------------------------------------
// temp_sensor_to_seven_segment_tb: self-checking bench for the sensor converter
// Writes calibration points, streams ADC samples through the valid/stall
// channels and checks every reading (held temperature, update flag and the
// four segment codes) against an in-bench model of the two-point conversion.
// ----------------------------------------------------------------------------
module temp_sensor_to_seven_segment_tb;

	// conversion constants, degrees C
	localparam int HOT_DEG  = 110;
	localparam int COLD_DEG = 30;
	localparam int MAX_DEG  = 100;

	localparam int NUM_PHASES     = 12;
	localparam int PHASE_ITEMS    = 80;
	localparam int HOLD_PHASE     = 2;    // phase with the long output hold-off
	localparam int HOLD_CYCLES    = 300;
	localparam int SETTLE_CYCLES  = 30;   // idle time after the last owed reading is out
	localparam int TIMEOUT        = 10_000_000;

	// common-cathode digit codes, bit0 = segment a
	localparam logic [7:0] SEG_LUT [10] = '{
		8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
	};

	// one output transfer as the bench expects it
	typedef struct packed {
		logic [tss_pkg::TEMP_W-1:0] temp;
		logic                       upd;
		logic [tss_pkg::SEG_W-1:0]  ones;
		logic [tss_pkg::SEG_W-1:0]  tens;
		logic [tss_pkg::SEG_W-1:0]  hund;
		logic [tss_pkg::SEG_W-1:0]  thou;
	} reading_t;

	// directed stimulus row; a row with new_cal drains the block and rewrites
	// both points first, a row with lit carries a hand-typed expectation
	typedef struct packed {
		logic                         new_cal;
		logic [tss_pkg::CAL_W-1:0]    lo;
		logic [tss_pkg::CAL_W-1:0]    hi;
		logic [tss_pkg::SAMPLE_W-1:0] smp;
		logic                         lit;
		logic [tss_pkg::TEMP_W-1:0]   temp;
		logic                         upd;
	} dir_row_t;

	localparam int NUM_DIR = 24;
	localparam dir_row_t DIRECTED [NUM_DIR] = '{
		// reset calibration: low 1750, high 1330, divisor -420
		'{1'b0, 12'd0,    12'd0,    12'd0,    1'b1, 7'd0,   1'b0}, // nothing held yet
		'{1'b0, 12'd0,    12'd0,    12'd4095, 1'b1, 7'd0,   1'b0}, // far below range
		'{1'b0, 12'd0,    12'd0,    12'd1750, 1'b1, 7'd30,  1'b1}, // at the low point
		'{1'b0, 12'd0,    12'd0,    12'd1330, 1'b1, 7'd30,  1'b0}, // 110 C, too hot
		'{1'b0, 12'd0,    12'd0,    12'd1855, 1'b1, 7'd10,  1'b1},
		'{1'b0, 12'd0,    12'd0,    12'd1382, 1'b1, 7'd100, 1'b1}, // top of range
		'{1'b0, 12'd0,    12'd0,    12'd1377, 1'b1, 7'd100, 1'b0}, // 101, rejected
		'{1'b0, 12'd0,    12'd0,    12'd1903, 1'b1, 7'd1,   1'b1}, // bottom of range
		'{1'b0, 12'd0,    12'd0,    12'd1908, 1'b1, 7'd1,   1'b0}, // 0, rejected
		'{1'b0, 12'd0,    12'd0,    12'd1902, 1'b0, 7'd0,   1'b0},
		// equal points: zero divisor, value kept
		'{1'b1, 12'd2000, 12'd2000, 12'd2000, 1'b1, 7'd2,   1'b0},
		'{1'b0, 12'd0,    12'd0,    12'd0,    1'b1, 7'd2,   1'b0},
		// widest positive span
		'{1'b1, 12'd0,    12'd4095, 12'd0,    1'b1, 7'd30,  1'b1},
		'{1'b0, 12'd0,    12'd0,    12'd4095, 1'b1, 7'd30,  1'b0},
		'{1'b0, 12'd0,    12'd0,    12'd3582, 1'b0, 7'd0,   1'b0},
		'{1'b0, 12'd0,    12'd0,    12'd3584, 1'b0, 7'd0,   1'b0},
		// widest negative span
		'{1'b1, 12'd4095, 12'd0,    12'd4095, 1'b1, 7'd30,  1'b1},
		'{1'b0, 12'd0,    12'd0,    12'd0,    1'b1, 7'd30,  1'b0},
		'{1'b0, 12'd0,    12'd0,    12'd2730, 1'b0, 7'd0,   1'b0},
		// equal points at full scale
		'{1'b1, 12'd4095, 12'd4095, 12'd4095, 1'b0, 7'd0,   1'b0},
		// one-count spans, huge quotients
		'{1'b1, 12'd0,    12'd1,    12'd0,    1'b1, 7'd30,  1'b1},
		'{1'b0, 12'd0,    12'd0,    12'd1,    1'b1, 7'd30,  1'b0},
		'{1'b1, 12'd1,    12'd0,    12'd1,    1'b1, 7'd30,  1'b1},
		'{1'b0, 12'd0,    12'd0,    12'd4095, 1'b1, 7'd30,  1'b0}
	};

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [tss_pkg::IDX_W-1:0]       cfg_index;
	logic [tss_pkg::CAL_W-1:0]       cfg_data;
	logic                            in_valid;
	logic                            in_stall;
	logic [tss_pkg::SAMPLE_W-1:0]    sample;
	logic                            out_valid;
	logic                            out_stall;
	logic [tss_pkg::TEMP_W-1:0]      shown_temp;
	logic                            updated;
	logic [tss_pkg::SEG_W-1:0]       seg_ones;
	logic [tss_pkg::SEG_W-1:0]       seg_tens;
	logic [tss_pkg::SEG_W-1:0]       seg_hundreds;
	logic [tss_pkg::SEG_W-1:0]       seg_thousands;

	// bench copy of the block state and calibration
	logic [tss_pkg::CAL_W-1:0]       cal_lo;
	logic [tss_pkg::CAL_W-1:0]       cal_hi;
	logic [tss_pkg::TEMP_W-1:0]      held_deg;

	reading_t pending_readings [$];   // readings owed by the block, oldest first
	int       n_err;
	int       gap_pct;                // chance of a sender gap after a transfer
	int       stall_pct;              // chance of a receiver stall burst
	bit       hold_off_req;           // asks the receiver for one long hold-off

	temp_sensor_to_seven_segment u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.sample        (sample),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.shown_temp    (shown_temp),
		.updated       (updated),
		.seg_ones      (seg_ones),
		.seg_tens      (seg_tens),
		.seg_hundreds  (seg_hundreds),
		.seg_thousands (seg_thousands)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#TIMEOUT;
		$display("Some tests failed");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Model of the conversion
	// ------------------------------------------------------------------------

	// digit split of a held temperature into segment codes
	function automatic reading_t show_temp(input logic [tss_pkg::TEMP_W-1:0] t,
			input logic ok);
		reading_t r;
		int       v;
		v      = int'(t);
		r.temp = t;
		r.upd  = ok;
		r.ones = SEG_LUT[v % 10];
		r.tens = SEG_LUT[(v % 100) / 10];
		r.hund = SEG_LUT[(v % 1000) / 100];
		r.thou = SEG_LUT[(v / 1000) % 10];
		return r;
	endfunction

	// two-point calibration; SV int division truncates toward zero like the
	// block is meant to. Out-of-range or zero-divisor results keep the old value.
	function automatic reading_t calibrate_sample(input logic [tss_pkg::SAMPLE_W-1:0] s,
			input logic [tss_pkg::CAL_W-1:0] lo, input logic [tss_pkg::CAL_W-1:0] hi,
			input logic [tss_pkg::TEMP_W-1:0] held);
		int                         span;
		int                         num;
		int                         t;
		logic [tss_pkg::TEMP_W-1:0] nxt;
		logic                       ok;
		span = int'(hi) - int'(lo);
		nxt  = held;
		ok   = 1'b0;
		if (span != 0) begin
			num = (int'(s) - int'(lo)) * (HOT_DEG - COLD_DEG);
			t   = num / span + COLD_DEG;
			if (t >= 1 && t <= MAX_DEG) begin
				nxt = t[tss_pkg::TEMP_W-1:0];
				ok  = 1'b1;
			end
		end
		return show_temp(nxt, ok);
	endfunction

	// mostly samples around the accepted band so the held value keeps moving,
	// the rest anywhere on the ADC scale
	function automatic logic [tss_pkg::SAMPLE_W-1:0] pick_sample(
			input logic [tss_pkg::CAL_W-1:0] lo, input logic [tss_pkg::CAL_W-1:0] hi);
		int span;
		int q;
		int s;
		span = int'(hi) - int'(lo);
		if (span == 0 || $urandom_range(99, 0) < 30)
			return 12'($urandom_range(4095, 0));
		q = int'($urandom_range(104, 0)) - 32;      // target quotient -32..72
		s = int'(lo) + (span * q) / 80 + int'($urandom_range(4, 0)) - 2;
		if (s < 0)
			s = 0;
		if (s > 4095)
			s = 4095;
		return s[tss_pkg::SAMPLE_W-1:0];
	endfunction

	// ------------------------------------------------------------------------
	// Channel and register drivers
	// ------------------------------------------------------------------------

	// offer one sample, wait for the transfer, log what the block owes for it;
	// a hand-typed expectation replaces the model output for that row
	task automatic send_sample(input logic [tss_pkg::SAMPLE_W-1:0] s, input logic lit,
			input logic [tss_pkg::TEMP_W-1:0] lit_temp, input logic lit_upd);
		reading_t r;
		int       n;
		in_valid <= 1'b1;
		sample   <= s;
		do @(posedge clk); while (in_stall);
		r        = calibrate_sample(s, cal_lo, cal_hi, held_deg);
		held_deg = r.temp;
		if (lit)
			r = show_temp(lit_temp, lit_upd);
		pending_readings.push_back(r);
		if (gap_pct != 0 && $urandom_range(99, 0) < gap_pct) begin
			in_valid <= 1'b0;
			n = $urandom_range(14, 1);
			repeat (n) @(posedge clk);
		end
	endtask

	// stop offering and wait until every owed reading is out, then let the
	// pipeline settle so a register write cannot hit a conversion
	task automatic drain_block();
		in_valid <= 1'b0;
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_cal(input logic [tss_pkg::CAL_W-1:0] lo,
			input logic [tss_pkg::CAL_W-1:0] hi);
		cfg_we    <= 1'b1;
		cfg_index <= tss_pkg::REG_CAL_LOW;
		cfg_data  <= lo;
		@(posedge clk);
		cfg_index <= tss_pkg::REG_CAL_HIGH;
		cfg_data  <= hi;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cal_lo    = lo;
		cal_hi    = hi;
	endtask

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v,
				act_v);
			n_err++;
		end
	endtask

	// ------------------------------------------------------------------------
	// Receiver: random stall bursts, plus one long hold-off on request so the
	// block backs up and stalls its input while the sender keeps offering
	// ------------------------------------------------------------------------
	initial begin
		int n;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall    <= 1'b0;
				hold_off_req = 1'b0;
			end else if (stall_pct != 0 && $urandom_range(99, 0) < stall_pct) begin
				out_stall <= 1'b1;
				n = $urandom_range(14, 1);
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Output checker: every output transfer against the oldest owed reading
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		reading_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_readings.size() == 0) begin
				$display("%0t: unexpected output transfer, expected none actual temp %0d",
					$time, shown_temp);
				n_err++;
			end else begin
				exp_r = pending_readings.pop_front();
				check_field("shown_temp",    int'(exp_r.temp), int'(shown_temp));
				check_field("updated",       int'(exp_r.upd),  int'(updated));
				check_field("seg_ones",      int'(exp_r.ones), int'(seg_ones));
				check_field("seg_tens",      int'(exp_r.tens), int'(seg_tens));
				check_field("seg_hundreds",  int'(exp_r.hund), int'(seg_hundreds));
				check_field("seg_thousands", int'(exp_r.thou), int'(seg_thousands));
			end
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		logic [tss_pkg::CAL_W-1:0] lo;
		logic [tss_pkg::CAL_W-1:0] hi;
		int                        d;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = tss_pkg::REG_CAL_LOW;
		cfg_data     = '0;
		in_valid     = 1'b0;
		sample       = '0;
		cal_lo       = 12'd1750;   // reset calibration
		cal_hi       = 12'd1330;
		held_deg     = '0;
		n_err        = 0;
		gap_pct      = 0;
		stall_pct    = 0;
		hold_off_req = 1'b0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part: range edges, rejections, zero divisor, extreme spans;
		// light idling so gaps still land here
		gap_pct   = 20;
		stall_pct = 20;
		for (int i = 0; i < NUM_DIR; i++) begin
			if (DIRECTED[i].new_cal) begin
				drain_block();
				write_cal(DIRECTED[i].lo, DIRECTED[i].hi);
			end
			send_sample(DIRECTED[i].smp, DIRECTED[i].lit, DIRECTED[i].temp, DIRECTED[i].upd);
		end

		// random part: one calibration per phase, written with the block idle
		for (int p = 0; p < NUM_PHASES; p++) begin
			drain_block();
			case (p)
				0:              begin lo = 12'd1750; hi = 12'd1330; end
				1:              begin lo = 12'd0;    hi = 12'd4095; end
				2:              begin lo = 12'd4095; hi = 12'd0;    end
				3:              begin lo = 12'd2048; hi = 12'd2048; end
				4:              begin lo = 12'd3000; hi = 12'd3400; end
				NUM_PHASES - 1: begin lo = 12'd1750; hi = 12'd1330; end
				default: begin
					lo = 12'($urandom_range(4095, 0));
					if ($urandom_range(1, 0) == 0) begin
						hi = 12'($urandom_range(4095, 0));
					end else begin
						// narrow span on either side of the low point
						d = int'(lo) + ($urandom_range(1, 0) ? 1 : -1) *
							int'($urandom_range(200, 1));
						if (d < 0)
							d = 0;
						if (d > 4095)
							d = 4095;
						hi = d[tss_pkg::CAL_W-1:0];
					end
				end
			endcase
			write_cal(lo, hi);

			// idle mix per phase, none at all in the closing phase
			if (p == NUM_PHASES - 1) begin
				gap_pct   = 0;
				stall_pct = 0;
			end else begin
				case ($urandom_range(3, 0))
					0:       gap_pct = 0;
					1:       gap_pct = 10;
					2:       gap_pct = 30;
					default: gap_pct = 60;
				endcase
				case ($urandom_range(3, 0))
					0:       stall_pct = 0;
					1:       stall_pct = 10;
					2:       stall_pct = 30;
					default: stall_pct = 60;
				endcase
			end

			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == HOLD_PHASE && i == 20)
					hold_off_req = 1'b1;
				send_sample(pick_sample(cal_lo, cal_hi), 1'b0, '0, 1'b0);
			end
		end

		drain_block();
		if (n_err == 0 && pending_readings.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
